FILE: design/rsa_pkg.sv
// rsa_pkg: shared types and constants for the modular exponentiation block
// no dependencies
`default_nettype none
package rsa_pkg;
  localparam int unsigned KeyWidth = 64;
  localparam int unsigned CntW = $clog2(KeyWidth);

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusZero    = 2'd1,
    StatusRange   = 2'd2
  } status_e;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam logic [1:0] RegModulus = 2'd0;
  localparam logic [1:0] RegPubExp  = 2'd1;
  localparam logic [1:0] RegPrivExp = 2'd2;

  typedef struct packed {
    logic                command;
    logic [KeyWidth-1:0] block_value;
  } req_t;

  typedef struct packed {
    logic [KeyWidth-1:0] result_value;
    logic [1:0]          status;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle, StReduce, StSquare, StMult, StDone
  } state_e;

  // control between sequencer and multiplier
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage
`default_nettype wire

FILE: design/rsa_mulmod.sv
// rsa_mulmod: iterative shift-and-add modular multiplier, one bit per cycle
// depends on rsa_pkg
`default_nettype none
module rsa_mulmod import rsa_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [KeyWidth-1:0] a_i,
  input  wire logic [KeyWidth-1:0] b_i,
  input  wire logic [KeyWidth-1:0] n_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [KeyWidth-1:0]      p_o
);
  logic [KeyWidth-1:0] acc_q, acc_d, a_q, b_q, step1, step2;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, done_q;

  // add_mod(x,y): x >= n-y ? x-(n-y) : x+y
  function automatic logic [KeyWidth-1:0] add_mod(input logic [KeyWidth-1:0] x,
      input logic [KeyWidth-1:0] y, input logic [KeyWidth-1:0] n);
    logic [KeyWidth-1:0] room;
    room = n - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  always_comb begin
    step1 = add_mod(acc_q, acc_q, n_i);
    step2 = add_mod(step1, a_q, n_i);
    acc_d = b_q[KeyWidth-1] ? step2 : step1;
  end

  // one multiplier bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(KeyWidth-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[KeyWidth-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = acc_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("done without busy");
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("start did not set busy");
endmodule
`default_nettype wire

FILE: design/rsa_block_modexp.sv
// rsa_block_modexp: square-and-multiply sequencer around one modular multiplier
// depends on rsa_pkg and rsa_mulmod
// One request at a time. in_stall_o is high from acceptance until the result
// is taken. All arithmetic runs on one shift-and-add modular multiplier; each
// product starts as soon as the last one is done. A request that
// passes its checks first reduces the block modulo n as a product with one,
// then runs 64 squarings and one multiply per set exponent bit. A request
// that fails a check presents its result the cycle after acceptance.
`default_nettype none
module rsa_block_modexp import rsa_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [KeyWidth-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire req_t                in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rsp_t                     out_data_o
);
  logic [KeyWidth-1:0] n_q, e_q, d_q, exp_q, base_q, acc_q;
  logic [CntW-1:0]     bit_q;
  state_e              st_q, st_d;
  rsp_t                rsp_q;
  mul_ctl_t            mctl;
  logic                mdone, mbusy, accept, fire;
  logic [KeyWidth-1:0] mprod, ma, mb;
  logic [1:0]          chk;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; e_q <= '0; d_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegModulus: n_q <= cfg_data_i;
        RegPubExp:  e_q <= cfg_data_i;
        RegPrivExp: d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign fire = out_valid_o && !out_stall_i;

  // request checks
  always_comb begin
    chk = StatusOk;
    if (in_data_i.command == CmdEncrypt) begin
      if (e_q == '0 || n_q == '0) chk = StatusZero;
      else if (in_data_i.block_value >= n_q) chk = StatusRange;
    end else if (n_q == '0) chk = StatusZero;
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:   if (accept) st_d = (chk != StatusOk) ? StDone : StReduce;
      StReduce: if (mdone) st_d = StSquare;
      StSquare: if (mdone) st_d = exp_q[KeyWidth-1] ? StMult : (bit_q == '0 ? StDone : StSquare);
      StMult:   if (mdone) st_d = (bit_q == '0) ? StDone : StSquare;
      StDone:   if (fire) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  // multiplier control and operands
  always_comb begin
    mctl.busy  = mbusy;
    mctl.start = 1'b0;
    ma = mprod;
    mb = mprod;
    case (st_q)
      StIdle: begin
        // block times one reduces the block modulo n
        mctl.start = accept && (chk == StatusOk);
        ma = KeyWidth'(1);
        mb = in_data_i.block_value;
      end
      StReduce: begin
        mctl.start = mdone;
        ma = acc_q;
        mb = acc_q;
      end
      StSquare: begin
        mctl.start = mdone && (exp_q[KeyWidth-1] || bit_q != '0);
        if (exp_q[KeyWidth-1]) mb = base_q;
      end
      StMult:   mctl.start = mdone && (bit_q != '0);
      default:  mctl.start = 1'b0;
    endcase
  end

  rsa_mulmod u_mul (
    .clk_i, .rst_ni, .start_i(mctl.start), .a_i(ma), .b_i(mb), .n_i(n_q),
    .busy_o(mbusy), .done_o(mdone), .p_o(mprod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (accept) begin
        base_q <= in_data_i.block_value;
        exp_q  <= (in_data_i.command == CmdEncrypt) ? e_q : d_q;
        acc_q  <= (n_q == KeyWidth'(1)) ? '0 : KeyWidth'(1);
        bit_q  <= CntW'(KeyWidth-1);
        rsp_q.status       <= chk;
        rsp_q.result_value <= '0;
      end
      StReduce: if (mdone) begin
        base_q <= mprod;
      end
      StSquare: if (mdone) begin
        if (!exp_q[KeyWidth-1]) begin
          exp_q <= exp_q << 1;
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) rsp_q.result_value <= mprod;
        end
      end
      StMult: if (mdone) begin
        exp_q <= exp_q << 1;
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) rsp_q.result_value <= mprod;
      end
      default: ;
    endcase
  end

  assign out_valid_o = (st_q == StDone);
  assign out_data_o  = rsp_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rsp_q.status != StatusOk) |-> rsp_q.result_value == '0)
    else $error("error result not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> !mctl.busy) else $error("multiplier busy in idle");
endmodule
`default_nettype wire
